// ===== sv/multi_stack_queue_manager_core_macros.svh =====
// Assertion macros used by the multi-queue manager core RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef MULTI_STACK_QUEUE_MANAGER_CORE_MACROS_SVH
`define MULTI_STACK_QUEUE_MANAGER_CORE_MACROS_SVH

// A condition that must hold at every clock edge.
`define MSQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define MSQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define MSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/msq_pkg.sv =====
// Shared constants and types of the multi-queue manager.
// No dependencies; every other source file but the macro header imports it.
`default_nettype none

package msq_pkg;

  localparam int OP_W      = 2;
  localparam int LIST_ID_W = 4;
  localparam int VALUE_W   = 64;
  localparam int STATUS_W  = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EXISTS = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOLIST = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd4;

  // Update command from the sequencer to the list table.
  typedef struct packed {
    logic create;
    logic push_ok;
    logic pop_ok;
    logic fifo;
  } list_cmd_t;

  // Status of the addressed list as seen by the sequencer.
  typedef struct packed {
    logic valid;
    logic fifo;
    logic empty;
  } list_stat_t;

endpackage

`default_nettype wire

// ===== sv/msq_channels_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on msq_pkg for the payload widths.
`default_nettype none

interface msq_in_if
  import msq_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [LIST_ID_W-1:0] list_id;
  logic                 is_queue;
  logic [VALUE_W-1:0]   push_value;

  modport source (output valid, output operation, output list_id, output is_queue,
                  output push_value, input ready);
  modport sink   (input valid, input operation, input list_id, input is_queue,
                  input push_value, output ready);
endinterface

interface msq_out_if
  import msq_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  popped_value;

  modport source (output valid, output status, output popped_value, input ready);
  modport sink   (input valid, input status, input popped_value, output ready);
endinterface

`default_nettype wire

// ===== sv/msq_list_table.sv =====
// Per-list descriptor table: valid, mode, head, tail and entry count.
// Depends on msq_pkg; read and updated by the top-level sequencer.
`default_nettype none

module msq_list_table
  import msq_pkg::*;
#(
  parameter int NUM_LISTS = 16,
  parameter int NUM_NODES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [LIST_ID_W-1:0]           list_id,
  output list_stat_t                          stat,
  output logic [$clog2(NUM_NODES)-1:0]        head,
  output logic [$clog2(NUM_NODES)-1:0]        tail,
  input  list_cmd_t                           cmd,
  input  wire logic [$clog2(NUM_NODES)-1:0]   new_node,
  input  wire logic [$clog2(NUM_NODES)-1:0]   new_head
);

  localparam int NIW        = $clog2(NUM_NODES);
  localparam int CW         = $clog2(NUM_NODES + 1);
  localparam int MAX_IDS    = 2 ** LIST_ID_W;
  localparam int LIST_DEPTH = (NUM_LISTS < MAX_IDS) ? NUM_LISTS : MAX_IDS;
  localparam int LIW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int TD         = 2 ** LIW;

  logic [TD-1:0]  valid_r;
  logic [TD-1:0]  fifo_r;
  logic [CW-1:0]  count_r [TD];
  logic [NIW-1:0] head_r  [TD];
  logic [NIW-1:0] tail_r  [TD];

  logic [LIW-1:0] idx;
  logic           was_empty;

  assign idx        = list_id[LIW-1:0];
  assign was_empty  = (count_r[idx] == '0);

  assign stat.valid = valid_r[idx];
  assign stat.fifo  = fifo_r[idx];
  assign stat.empty = was_empty;
  assign head       = head_r[idx];
  assign tail       = tail_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fifo_r  <= '0;
      for (int i = 0; i < TD; i++) begin
        count_r[i] <= '0;
      end
    end else if (cmd.create) begin
      valid_r[idx] <= 1'b1;
      fifo_r[idx]  <= cmd.fifo;
      count_r[idx] <= '0;
    end else if (cmd.push_ok) begin
      count_r[idx] <= count_r[idx] + CW'(1);
    end else if (cmd.pop_ok) begin
      count_r[idx] <= count_r[idx] - CW'(1);
    end
  end

  // Pointers carry no reset; a list's head and tail are written by its first push.
  always_ff @(posedge clk) begin
    if (cmd.push_ok) begin
      if (was_empty) begin
        head_r[idx] <= new_node;
        tail_r[idx] <= new_node;
      end else if (fifo_r[idx]) begin
        tail_r[idx] <= new_node;
      end else begin
        head_r[idx] <= new_node;
      end
    end else if (cmd.pop_ok) begin
      head_r[idx] <= new_head;
    end
  end

endmodule

`default_nettype wire

// ===== sv/msq_node_pool.sv =====
// Shared node pool: value and link memories with registered reads.
// Depends on msq_pkg. Tracks which nodes were never handed out so that the
// power-on free chain needs no initialization pass.
`default_nettype none

module msq_node_pool
  import msq_pkg::*;
#(
  parameter int NUM_NODES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(NUM_NODES)-1:0]   rd_addr,
  output logic [VALUE_W-1:0]                  rd_data,
  output logic [$clog2(NUM_NODES)-1:0]        rd_link,
  input  wire logic                           data_we,
  input  wire logic [$clog2(NUM_NODES)-1:0]   data_addr,
  input  wire logic [VALUE_W-1:0]             data_wdata,
  input  wire logic                           link_we,
  input  wire logic [$clog2(NUM_NODES)-1:0]   link_addr,
  input  wire logic [$clog2(NUM_NODES)-1:0]   link_wdata
);

  localparam int NIW = $clog2(NUM_NODES);
  localparam int CW  = $clog2(NUM_NODES + 1);

  logic [VALUE_W-1:0] data_mem [NUM_NODES];
  logic [NIW-1:0]     link_mem [NUM_NODES];

  logic [VALUE_W-1:0] data_q;
  logic [NIW-1:0]     link_q;
  logic [NIW-1:0]     addr_q;
  logic               fresh_q;
  logic [CW-1:0]      fresh_mark_r;

  // Nodes are first handed out in ascending order, so every node at or above
  // the mark still holds its power-on link to the next node.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_mark_r <= '0;
    end else if (data_we && (CW'(data_addr) == fresh_mark_r)) begin
      fresh_mark_r <= fresh_mark_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_q  <= data_mem[rd_addr];
      link_q  <= link_mem[rd_addr];
      addr_q  <= rd_addr;
      fresh_q <= (CW'(rd_addr) == fresh_mark_r);
    end
    if (data_we) begin
      data_mem[data_addr] <= data_wdata;
    end
    if (link_we) begin
      link_mem[link_addr] <= link_wdata;
    end
  end

  assign rd_data = data_q;
  assign rd_link = !fresh_q ? link_q :
                   (addr_q == NIW'(NUM_NODES - 1)) ? '0 : addr_q + NIW'(1);

endmodule

`default_nettype wire

// ===== sv/multi_stack_queue_manager_core.sv =====
// Multi-list stack/queue manager over a shared linked node pool.
//
// in_chan carries one request: create a list (stack or queue), push a 64-bit
// value onto it, or pop its head. out_chan returns exactly one result per
// request, in order: a status code and, for a successful pop, the value.
// Both channels transfer on a clock edge with valid and ready high.
//
// A request is accepted in the idle state, which also issues the node memory
// read (the free-list head for a push, the list head for a pop). The execute
// state then decides the status, writes the node memories and loads the
// output register, once that register is free. No new request is taken
// until the execute state is done, due to the node pool's read-then-write.
//
// Reset clears every list and makes the whole pool free; the power-on free
// chain is tracked by a fill mark, so no clearing pass runs and requests are
// taken as soon as reset is released. A result waiting in the output register
// does not block acceptance of the next request; if the receiver still stalls
// when that request completes, it holds in its execute state and in_chan.ready
// stays low until the output register frees.
`default_nettype none

module multi_stack_queue_manager_core
  import msq_pkg::*;
#(
  parameter int NUM_LISTS = 16,
  parameter int NUM_NODES = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  msq_in_if.sink    in_chan,
  msq_out_if.source out_chan
);

`include "multi_stack_queue_manager_core_macros.svh"

  localparam int NIW = $clog2(NUM_NODES);
  localparam int CW  = $clog2(NUM_NODES + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]      op_r;
  logic [LIST_ID_W-1:0] id_r;
  logic                 queue_r;
  logic [VALUE_W-1:0]   val_r;

  logic [NIW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0]  free_count_r, free_count_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [VALUE_W-1:0]  popped_r;

  logic                 accept;
  logic                 exec_fire;
  logic [LIST_ID_W-1:0] tbl_id;
  list_stat_t           stat;
  list_cmd_t            cmd;
  logic [NIW-1:0]       head;
  logic [NIW-1:0]       tail;
  logic                 in_range;
  logic                 exists;
  logic [STATUS_W-1:0]  status_c;

  logic [NIW-1:0]     rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic [NIW-1:0]     rd_link;
  logic               link_we;
  logic [NIW-1:0]     link_addr;
  logic [NIW-1:0]     link_wdata;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign exec_fire     = (state_r == S_EXEC) && (!out_valid_r || out_chan.ready);

  // The table has one read port: the incoming request's list while idle,
  // the held request's list while executing.
  assign tbl_id = (state_r == S_IDLE) ? in_chan.list_id : id_r;

  msq_list_table #(
    .NUM_LISTS (NUM_LISTS),
    .NUM_NODES (NUM_NODES)
  ) u_list_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .list_id  (tbl_id),
    .stat     (stat),
    .head     (head),
    .tail     (tail),
    .cmd      (cmd),
    .new_node (free_head_r),
    .new_head (rd_link)
  );

  assign rd_addr = (in_chan.operation == OP_POP) ? head : free_head_r;

  msq_node_pool #(
    .NUM_NODES (NUM_NODES)
  ) u_node_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rd_link    (rd_link),
    .data_we    (cmd.push_ok),
    .data_addr  (free_head_r),
    .data_wdata (val_r),
    .link_we    (link_we),
    .link_addr  (link_addr),
    .link_wdata (link_wdata)
  );

  assign in_range = (32'(id_r) < NUM_LISTS);
  assign exists   = in_range && stat.valid;

  always_comb begin
    status_c    = STAT_OK;
    cmd.create  = 1'b0;
    cmd.push_ok = 1'b0;
    cmd.pop_ok  = 1'b0;
    cmd.fifo    = queue_r;
    case (op_r)
      OP_CREATE: begin
        if (!in_range) begin
          status_c = STAT_NOLIST;
        end else if (stat.valid) begin
          status_c = STAT_EXISTS;
        end else begin
          cmd.create = exec_fire;
        end
      end
      OP_PUSH: begin
        if (!exists) begin
          status_c = STAT_NOLIST;
        end else if (free_count_r == '0) begin
          status_c = STAT_FULL;
        end else begin
          cmd.push_ok = exec_fire;
        end
      end
      OP_POP: begin
        if (!exists) begin
          status_c = STAT_NOLIST;
        end else if (stat.empty) begin
          status_c = STAT_EMPTY;
        end else begin
          cmd.pop_ok = exec_fire;
        end
      end
      default: begin
        status_c = STAT_OK;
      end
    endcase
  end

  // The tail node's link is never followed, so a push into an empty list
  // writes no link, and a queue push writes only the old tail's link.
  always_comb begin
    link_we    = 1'b0;
    link_addr  = free_head_r;
    link_wdata = head;
    if (cmd.push_ok && !stat.empty) begin
      link_we = 1'b1;
      if (stat.fifo) begin
        link_addr  = tail;
        link_wdata = free_head_r;
      end
    end else if (cmd.pop_ok) begin
      link_we    = 1'b1;
      link_addr  = head;
      link_wdata = free_head_r;
    end
  end

  always_comb begin
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    if (cmd.push_ok) begin
      free_head_nxt  = rd_link;
      free_count_nxt = free_count_r - CW'(1);
    end else if (cmd.pop_ok) begin
      free_head_nxt  = head;
      free_count_nxt = free_count_r + CW'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= '0;
      free_count_r <= CW'(NUM_NODES);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      free_count_r <= free_count_nxt;
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_chan.operation;
      id_r    <= in_chan.list_id;
      queue_r <= in_chan.is_queue;
      val_r   <= in_chan.push_value;
    end
    if (exec_fire) begin
      status_r <= status_c;
      popped_r <= cmd.pop_ok ? rd_data : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.popped_value = popped_r;

  `MSQ_ASSERT_SAME(a_busy_blocks_input, state_r == S_EXEC, !in_chan.ready,
                   "request accepted while one is executing")
  `MSQ_ASSERT_ALWAYS(a_free_count_bound, free_count_r <= CW'(NUM_NODES),
                     "free node count above pool size")
  `MSQ_ASSERT_NEXT(a_push_takes_node, cmd.push_ok,
                   free_count_r == $past(free_count_r) - CW'(1),
                   "successful push did not consume a node")
  `MSQ_ASSERT_NEXT(a_exec_gives_result, exec_fire, out_chan.valid,
                   "completed request left no result")

endmodule

`default_nettype wire

// ===== test/multi_stack_queue_manager_core_test.sv =====
`timescale 1ns / 100ps

// Self-checking regression for multi_stack_queue_manager_core: a directed request table
// and random list traffic, scored against fixed answers or a behavioral predictor.
// Depends on msq_pkg, the channel interfaces in msq_channels_if.sv and the core RTL.
module multi_stack_queue_manager_core_test;
  import msq_pkg::*;

  localparam int LIST_CNT    = 16;
  localparam int NODE_CNT    = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 10;

  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [VALUE_W-1:0]   ALL_ONES   = '1;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [LIST_ID_W-1:0] list_id;
    logic                 is_queue;
    logic [VALUE_W-1:0]   push_value;
  } msq_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  popped_value;
  } msq_res_t;

  typedef struct packed {
    msq_req_t req;
    logic     fixed;
    msq_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle;
  int   mismatches = 0;
  int   cycle_count = 0;

  msq_in_if  req_if ();
  msq_out_if res_if ();

  multi_stack_queue_manager_core #(
    .NUM_LISTS (LIST_CNT),
    .NUM_NODES (NODE_CNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  // Predicted list table and node pool.
  bit                 list_live  [LIST_CNT];
  bit                 list_fifo  [LIST_CNT];
  int unsigned        list_head  [LIST_CNT];
  int unsigned        list_tail  [LIST_CNT];
  int unsigned        list_depth [LIST_CNT];
  logic [VALUE_W-1:0] node_value [NODE_CNT];
  int unsigned        node_next  [NODE_CNT];
  int unsigned        free_top;
  int unsigned        free_left;

  msq_res_t pending_results [$];
  dir_row_t dir_table [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_stack_queue_manager_core regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one request to the predicted lists and returns the result it should produce.
  function automatic msq_res_t apply_list_op(input msq_req_t r);
    msq_res_t    res;
    int unsigned id;
    int unsigned n;
    res.status       = STAT_OK;
    res.popped_value = '0;
    id = 32'(r.list_id);
    case (r.operation)
      OP_CREATE: begin
        if (id >= LIST_CNT) res.status = STAT_NOLIST;
        else if (list_live[id]) res.status = STAT_EXISTS;
        else begin
          list_live[id]  = 1'b1;
          list_fifo[id]  = r.is_queue;
          list_depth[id] = 0;
        end
      end
      OP_PUSH: begin
        if (id >= LIST_CNT || !list_live[id]) res.status = STAT_NOLIST;
        else if (free_left == 0) res.status = STAT_FULL;
        else begin
          n = free_top % NODE_CNT;
          free_top = node_next[n] % NODE_CNT;
          free_left--;
          node_value[n] = r.push_value;
          if (list_depth[id] == 0) begin
            node_next[n]  = 0;
            list_head[id] = n;
            list_tail[id] = n;
          end else if (list_fifo[id]) begin
            node_next[list_tail[id] % NODE_CNT] = n;
            node_next[n]  = 0;
            list_tail[id] = n;
          end else begin
            node_next[n]  = list_head[id];
            list_head[id] = n;
          end
          list_depth[id]++;
        end
      end
      OP_POP: begin
        if (id >= LIST_CNT || !list_live[id]) res.status = STAT_NOLIST;
        else if (list_depth[id] == 0) res.status = STAT_EMPTY;
        else begin
          n = list_head[id] % NODE_CNT;
          res.popped_value = node_value[n];
          list_head[id] = node_next[n] % NODE_CNT;
          list_depth[id]--;
          node_next[n] = free_top;
          free_top = n;
          free_left++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly lists that exist, now and then any id at all.
  function automatic logic [LIST_ID_W-1:0] pick_list_id();
    int live_ids [$];
    for (int i = 0; i < LIST_CNT; i++) if (list_live[i]) live_ids.push_back(i);
    if (live_ids.size() == 0 || $urandom_range(0, 7) == 0)
      return LIST_ID_W'($urandom_range(0, LIST_CNT - 1));
    return LIST_ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
  endfunction

  function automatic msq_req_t random_request(input int push_pct, input int pop_pct);
    msq_req_t r;
    int       roll;
    int       val_roll;
    roll     = $urandom_range(0, 99);
    val_roll = $urandom_range(0, 15);
    r.is_queue   = 1'($urandom_range(0, 1));
    r.push_value = (val_roll == 0) ? '0 : (val_roll == 1) ? ALL_ONES : {$urandom, $urandom};
    if (roll < push_pct) r.operation = OP_PUSH;
    else if (roll < push_pct + pop_pct) r.operation = OP_POP;
    else if (roll < 97) r.operation = OP_CREATE;
    else r.operation = OP_UNUSED;
    if (r.operation == OP_CREATE) begin
      r.list_id = LIST_ID_W'($urandom_range(0, LIST_CNT - 1));
    end else begin
      r.list_id = pick_list_id();
    end
    return r;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [LIST_ID_W-1:0] id,
                         input logic q, input logic [VALUE_W-1:0] val, input logic fixed,
                         input logic [STATUS_W-1:0] status, input logic [VALUE_W-1:0] popped);
    dir_row_t row;
    row.req   = '{operation: op, list_id: id, is_queue: q, push_value: val};
    row.fixed = fixed;
    row.res   = '{status: status, popped_value: popped};
    dir_table.push_back(row);
  endtask

  // Holds the request on the channel until it is taken, then records what it should return.
  // Valid stays high straight into the next request when no gap is drawn.
  task automatic send_request(input msq_req_t r, input logic fixed, input msq_res_t fixed_res);
    int       gap;
    msq_res_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= r.operation;
    req_if.list_id    <= r.list_id;
    req_if.is_queue   <= r.is_queue;
    req_if.push_value <= r.push_value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = apply_list_op(r);
    pending_results.push_back(fixed ? fixed_res : predicted);
  endtask

  initial begin : result_sink
    int span;
    forever begin
      span = pick_gap();
      if (span > 0) begin
        res_if.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    msq_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with status %0d and no request pending",
                                  res_if.status));
      end else begin
        want = pending_results.pop_front();
        if (res_if.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", res_if.status, want.status));
        if (res_if.popped_value !== want.popped_value)
          report_mismatch($sformatf("popped value %h, expected %h",
                                    res_if.popped_value, want.popped_value));
      end
    end
  end

  initial begin : stimulus
    req_if.valid      = 1'b0;
    req_if.operation  = OP_CREATE;
    req_if.list_id    = '0;
    req_if.is_queue   = 1'b0;
    req_if.push_value = '0;
    rst_n             = 1'b0;
    no_idle           = 1'b0;

    for (int i = 0; i < LIST_CNT; i++) begin
      list_live[i]  = 1'b0;
      list_fifo[i]  = 1'b0;
      list_head[i]  = 0;
      list_tail[i]  = 0;
      list_depth[i] = 0;
    end
    for (int i = 0; i < NODE_CNT; i++) begin
      node_value[i] = '0;
      node_next[i]  = (i + 1 < NODE_CNT) ? i + 1 : 0;
    end
    free_top  = 0;
    free_left = NODE_CNT;

    // Rows with fixed = 1 carry their answer; the rest are scored by the predictor.
    add_row(OP_POP,    4'd0,  1'b0, '0,                    1'b1, STAT_NOLIST, '0);
    add_row(OP_PUSH,   4'd15, 1'b0, ALL_ONES,              1'b1, STAT_NOLIST, '0);
    add_row(OP_CREATE, 4'd0,  1'b0, '0,                    1'b1, STAT_OK,     '0);
    add_row(OP_CREATE, 4'd0,  1'b1, '0,                    1'b1, STAT_EXISTS, '0);
    add_row(OP_POP,    4'd0,  1'b0, '0,                    1'b1, STAT_EMPTY,  '0);
    add_row(OP_CREATE, 4'd15, 1'b1, '0,                    1'b1, STAT_OK,     '0);
    add_row(OP_PUSH,   4'd0,  1'b0, '0,                    1'b1, STAT_OK,     '0);
    add_row(OP_PUSH,   4'd0,  1'b1, ALL_ONES,              1'b1, STAT_OK,     '0);
    add_row(OP_PUSH,   4'd0,  1'b0, 64'h5555_5555_5555_5555, 1'b1, STAT_OK,   '0);
    add_row(OP_POP,    4'd0,  1'b0, '0,                    1'b0, STAT_OK,     '0);
    add_row(OP_POP,    4'd0,  1'b0, '0,                    1'b0, STAT_OK,     '0);
    add_row(OP_POP,    4'd0,  1'b0, '0,                    1'b0, STAT_OK,     '0);
    add_row(OP_POP,    4'd0,  1'b0, '0,                    1'b1, STAT_EMPTY,  '0);
    add_row(OP_PUSH,   4'd15, 1'b0, 64'h8000_0000_0000_0001, 1'b1, STAT_OK,   '0);
    add_row(OP_PUSH,   4'd15, 1'b0, 64'h0123_4567_89ab_cdef, 1'b1, STAT_OK,   '0);
    add_row(OP_PUSH,   4'd15, 1'b0, ALL_ONES,              1'b1, STAT_OK,     '0);
    add_row(OP_UNUSED, 4'd15, 1'b1, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, STAT_OK,   '0);
    add_row(OP_POP,    4'd15, 1'b0, '0,                    1'b0, STAT_OK,     '0);
    add_row(OP_PUSH,   4'd0,  1'b0, 64'hfedc_ba98_7654_3210, 1'b0, STAT_OK,   '0);
    add_row(OP_POP,    4'd15, 1'b0, '0,                    1'b0, STAT_OK,     '0);
    add_row(OP_POP,    4'd15, 1'b0, '0,                    1'b0, STAT_OK,     '0);
    add_row(OP_POP,    4'd15, 1'b0, '0,                    1'b1, STAT_EMPTY,  '0);
    add_row(OP_POP,    4'd0,  1'b0, '0,                    1'b0, STAT_OK,     '0);
    add_row(OP_CREATE, 4'd7,  1'b1, '0,                    1'b1, STAT_OK,     '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) send_request(dir_table[i].req, dir_table[i].fixed, dir_table[i].res);

    // Alternate push-heavy and pop-heavy phases so lists grow deep and empty again.
    for (int phase = 0; phase < 13; phase++) begin
      no_idle = (phase % 4 == 3);
      for (int k = 0; k < 50; k++) begin
        if (phase % 2 == 0) send_request(random_request(55, 35), 1'b0, '0);
        else send_request(random_request(35, 55), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("multi_stack_queue_manager_core regression: pass");
    end else begin
      $display("multi_stack_queue_manager_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/msq_pkg.sv
sv/msq_channels_if.sv
sv/msq_list_table.sv
sv/msq_node_pool.sv
sv/multi_stack_queue_manager_core.sv
test/multi_stack_queue_manager_core_test.sv
